// ===== design/kpc_pkg.sv =====
// kpc_pkg: shared types and constants for the key press classifier
// holds event codes, register indexes, reset values and the classify result struct
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package kpc_pkg;

	localparam int CNT_W     = 8;
	localparam int TICKS_W   = 9;
	localparam int CFG_IDX_W = 2;

	localparam logic [TICKS_W-1:0] TICKS_MAX = '1;

	localparam logic [CNT_W-1:0] BASE_RESET = 8'd3;
	localparam logic [CNT_W-1:0] LONG_RESET = 8'd75;
	localparam logic [CNT_W-1:0] HOLD_RESET = 8'd15;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_BASE = 2'd0,
		CFG_LONG = 2'd1,
		CFG_HOLD = 2'd2
	} cfg_index_t;

	typedef enum logic [1:0] {
		EV_SHORT        = 2'd0,
		EV_LONG         = 2'd1,
		EV_HOLD         = 2'd2,
		EV_LONG_RELEASE = 2'd3
	} event_code_t;

	typedef struct packed {
		logic        valid;
		event_code_t code;
		logic        clr;
	} kpc_result_t;

endpackage

`default_nettype wire

// ===== design/kpc_classify.sv =====
// kpc_classify: per-tick classification and counter update
// pure combinational logic between the stage 1 register and the result register
// depends on kpc_pkg
`timescale 1ns / 1ps
`default_nettype none

module kpc_classify (
	input  wire logic                        key_pressed,
	input  wire logic                        was_pressed,
	input  wire logic [kpc_pkg::TICKS_W-1:0] press_ticks,
	input  wire logic [kpc_pkg::CNT_W-1:0]   base_count,
	input  wire logic [kpc_pkg::CNT_W-1:0]   long_count,
	input  wire logic [kpc_pkg::CNT_W-1:0]   hold_count,
	output kpc_pkg::kpc_result_t             result,
	output logic      [kpc_pkg::TICKS_W-1:0] press_ticks_next
);
	import kpc_pkg::*;

	logic [TICKS_W-1:0] ticks_inc;
	logic [TICKS_W-1:0] long_ext;
	logic [TICKS_W-1:0] repeat_at;

	assign long_ext  = {1'b0, long_count};
	assign repeat_at = long_ext + {1'b0, hold_count};
	// counter saturates rather than wrapping
	assign ticks_inc = (press_ticks == TICKS_MAX) ? press_ticks : press_ticks + 1'b1;

	always_comb begin
		result           = '0;
		result.code      = EV_SHORT;
		press_ticks_next = '0;
		if (!key_pressed) begin
			if (was_pressed) begin
				if (press_ticks >= long_ext) begin
					result.valid = 1'b1;
					result.code  = EV_LONG_RELEASE;
					result.clr   = 1'b1;
				end else if (press_ticks >= {1'b0, base_count}) begin
					result.valid = 1'b1;
					result.code  = EV_SHORT;
				end
			end
		end else if (was_pressed) begin
			press_ticks_next = ticks_inc;
			if (ticks_inc == long_ext) begin
				result.valid = 1'b1;
				result.code  = EV_LONG;
			end else if (ticks_inc == repeat_at) begin
				// fall back so hold events repeat
				result.valid     = 1'b1;
				result.code      = EV_HOLD;
				press_ticks_next = long_ext;
			end
		end
	end

endmodule

`default_nettype wire

// ===== design/key_press_classifier_core.sv =====
// key_press_classifier_core: short / long / hold / long-release button event detector
// a sample is registered in stage 1, then any event it gives in the output register
// throughput: one key sample per cycle, unless a sample with an event waits on a stalled output
// samples that give no event produce no output transaction
// reset: thresholds return to 3 / 75 / 15, counter cleared, key taken as released
// depends on kpc_pkg and kpc_classify
`timescale 1ns / 1ps
`default_nettype none

module key_press_classifier_core (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_write,
	input  wire logic [kpc_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [kpc_pkg::CNT_W-1:0]     cfg_data,
	input  wire logic                          in_valid,
	output logic                               in_stall,
	input  wire logic                          key_pressed,
	output logic                               out_valid,
	input  wire logic                          out_stall,
	output logic [1:0]                         event_code,
	output logic                               clear_queue
);
	import kpc_pkg::*;

	logic [CNT_W-1:0]   base_q;
	logic [CNT_W-1:0]   long_q;
	logic [CNT_W-1:0]   hold_q;
	logic [TICKS_W-1:0] press_ticks_q;
	logic               was_pressed_q;

	logic               valid_s1;
	logic               key_s1;

	logic               out_valid_q;
	event_code_t        out_code_q;
	logic               out_clr_q;

	kpc_result_t        res;
	logic [TICKS_W-1:0] ticks_next;
	logic               out_free;
	logic               s1_adv;
	logic               in_acc;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q <= BASE_RESET;
			long_q <= LONG_RESET;
			hold_q <= HOLD_RESET;
		end else if (cfg_write) begin
			case (cfg_index)
				CFG_BASE: base_q <= cfg_data;
				CFG_LONG: long_q <= cfg_data;
				CFG_HOLD: hold_q <= cfg_data;
				default: ;
			endcase
		end
	end

	kpc_classify u_classify (
		.key_pressed      (key_s1),
		.was_pressed      (was_pressed_q),
		.press_ticks      (press_ticks_q),
		.base_count       (base_q),
		.long_count       (long_q),
		.hold_count       (hold_q),
		.result           (res),
		.press_ticks_next (ticks_next)
	);

	assign out_free = !out_valid_q || !out_stall;
	// a sample with no event never waits for the output side
	assign s1_adv   = valid_s1 && (!res.valid || out_free);
	assign in_stall = valid_s1 && !s1_adv;
	assign in_acc   = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1      <= 1'b0;
			press_ticks_q <= '0;
			was_pressed_q <= 1'b0;
			out_valid_q   <= 1'b0;
		end else begin
			if (in_acc) begin
				valid_s1 <= 1'b1;
			end else if (s1_adv) begin
				valid_s1 <= 1'b0;
			end
			if (s1_adv) begin
				press_ticks_q <= ticks_next;
				was_pressed_q <= key_s1;
			end
			if (s1_adv && res.valid) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			key_s1 <= key_pressed;
		end
		if (s1_adv && res.valid) begin
			out_code_q <= res.code;
			out_clr_q  <= res.clr;
		end
	end

	assign out_valid   = out_valid_q;
	assign event_code  = out_code_q;
	assign clear_queue = out_clr_q;

	// counter only runs while the key is held
	assert property (@(posedge clk) disable iff (!arst_n)
		!was_pressed_q |-> press_ticks_q == '0)
		else $error("press counter non-zero while key released");

	// clear-queue flag only travels with a long release
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_clr_q |-> out_code_q == EV_LONG_RELEASE)
		else $error("clear_queue without long release");

	// a hold event folds the counter back to the long threshold
	assert property (@(posedge clk) disable iff (!arst_n)
		s1_adv && res.valid && res.code == EV_HOLD
		|=> press_ticks_q == {1'b0, $past(long_q)})
		else $error("counter not folded back after hold event");

	// a blocked stage 1 sample is kept, not dropped
	assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !s1_adv |=> valid_s1 && $stable(key_s1))
		else $error("stalled stage 1 sample lost");

endmodule

`default_nettype wire

// ===== sim/key_press_classifier_core_tb.sv =====
// testbench for key_press_classifier_core: directed press table, then random presses
// checks every output transaction against a local short / long / hold / release predictor
// depends on kpc_pkg and the key_press_classifier_core rtl
`timescale 1ns / 1ps

module key_press_classifier_core_tb;
	import kpc_pkg::*;

	localparam int HALF_PERIOD_NS  = 2;
	localparam int RESET_CYCLES    = 9;
	localparam int SETTLE_CYCLES   = 6;
	localparam int END_WAIT_CYCLES = 2000;
	localparam int RANDOM_ITEMS    = 120;
	localparam int OVERFLOW_PRESS  = 515;
	localparam int TIMEOUT_NS      = 2_000_000;

	// index past the last register, must be ignored by the block
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

	typedef enum logic [1:0] {
		REL_NONE,
		REL_SHORT,
		REL_LONG,
		REL_ANY
	} release_kind_t;

	typedef struct packed {
		logic [CNT_W-1:0] base;
		logic [CNT_W-1:0] lng;
		logic [CNT_W-1:0] hold;
		int               presses;
		release_kind_t    rel;
	} press_row_t;

	logic                 clk         = 1'b0;
	logic                 arst_n      = 1'b0;
	logic                 cfg_write   = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index   = CFG_BASE;
	logic [CNT_W-1:0]     cfg_data    = '0;
	logic                 in_valid    = 1'b0;
	logic                 key_pressed = 1'b0;
	logic                 out_stall   = 1'b0;
	logic                 in_stall;
	logic                 out_valid;
	logic [1:0]           event_code;
	logic                 clear_queue;

	// predictor state and its copy of the thresholds
	logic [CNT_W-1:0]   thr_base  = BASE_RESET;
	logic [CNT_W-1:0]   thr_long  = LONG_RESET;
	logic [CNT_W-1:0]   thr_hold  = HOLD_RESET;
	logic [TICKS_W-1:0] press_cnt = '0;
	logic               key_held  = 1'b0;

	kpc_result_t pending_events[$];
	kpc_result_t last_release = '0;

	int idle_in_pct    = 0;
	int stall_pct      = 0;
	int errors         = 0;
	int samples_taken  = 0;
	int events_seen    = 0;
	int settings_used  = 0;

	// length of press, number of pressed samples before the release
	press_row_t directed_rows [8] = '{
		'{8'd3,   8'd75,  8'd15,  0, REL_NONE},
		'{8'd3,   8'd75,  8'd15,  4, REL_SHORT},
		'{8'd1,   8'd2,   8'd1,   6, REL_LONG},
		'{8'd255, 8'd255, 8'd255, 2, REL_NONE},
		'{8'd0,   8'd1,   8'd0,   4, REL_ANY},
		'{8'd0,   8'd9,   8'd3,   1, REL_ANY},
		'{8'd4,   8'd0,   8'd2,   3, REL_ANY},
		'{8'd2,   8'd2,   8'd9,   3, REL_ANY}
	};

	key_press_classifier_core i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_write   (cfg_write),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.key_pressed (key_pressed),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.event_code  (event_code),
		.clear_queue (clear_queue)
	);

	always #(HALF_PERIOD_NS) clk = ~clk;

	always @(posedge clk) begin
		out_stall <= ($urandom_range(99) < stall_pct);
	end

	function automatic kpc_result_t classify_sample(input logic pressed);
		kpc_result_t        res;
		logic [TICKS_W-1:0] hold_mark;
		res       = '0;
		hold_mark = {1'b0, thr_long} + {1'b0, thr_hold};
		if (!pressed) begin
			if (key_held) begin
				if (press_cnt >= {1'b0, thr_long}) begin
					res.valid = 1'b1;
					res.code  = EV_LONG_RELEASE;
					res.clr   = 1'b1;
				end else if (press_cnt >= {1'b0, thr_base}) begin
					res.valid = 1'b1;
					res.code  = EV_SHORT;
				end
			end
			press_cnt = '0;
		end else if (!key_held) begin
			press_cnt = '0;
		end else begin
			if (press_cnt != TICKS_MAX)
				press_cnt = press_cnt + 1'b1;
			if (press_cnt == {1'b0, thr_long}) begin
				res.valid = 1'b1;
				res.code  = EV_LONG;
			end else if (press_cnt == hold_mark) begin
				res.valid = 1'b1;
				res.code  = EV_HOLD;
				press_cnt = {1'b0, thr_long};
			end
		end
		key_held = pressed;
		return res;
	endfunction

	always @(posedge clk) begin : monitor
		kpc_result_t fresh;
		kpc_result_t want;
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				fresh = classify_sample(key_pressed);
				if (!key_pressed)
					last_release = fresh;
				if (fresh.valid)
					pending_events.push_back(fresh);
				samples_taken++;
			end
			if (out_valid && !out_stall) begin
				events_seen++;
				if (pending_events.size() == 0) begin
					$error("unexpected transaction: event_code %0d clear_queue %0b",
						event_code, clear_queue);
					errors++;
				end else begin
					want = pending_events.pop_front();
					if (event_code !== want.code) begin
						$error("event_code: expected %0d, got %0d", want.code, event_code);
						errors++;
					end
					if (clear_queue !== want.clr) begin
						$error("clear_queue: expected %0b, got %0b", want.clr, clear_queue);
						errors++;
					end
				end
			end
		end
	end

	// holds the sample until the block takes it; returns just after the accepting edge
	task automatic send_key(input logic level);
		logic taken;
		while ($urandom_range(99) < idle_in_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid    <= 1'b1;
		key_pressed <= level;
		do begin
			@(negedge clk);
			taken = !in_stall;
			@(posedge clk);
		end while (!taken);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		do @(posedge clk); while (pending_events.size() != 0);
		// samples with no event may still be in flight
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CNT_W-1:0] val);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
	endtask

	task automatic reconfigure(input logic [CNT_W-1:0] b, input logic [CNT_W-1:0] l,
			input logic [CNT_W-1:0] h);
		drain();
		write_reg(CFG_SPARE, CNT_W'($urandom_range(255)));
		write_reg(CFG_BASE, b);
		write_reg(CFG_LONG, l);
		write_reg(CFG_HOLD, h);
		cfg_write <= 1'b0;
		thr_base = b;
		thr_long = l;
		thr_hold = h;
		settings_used++;
	endtask

	function automatic logic [CNT_W-1:0] pick_threshold(input int top);
		if ($urandom_range(9) == 0)
			return '0;
		return CNT_W'($urandom_range(top, 1));
	endfunction

	task automatic play_row(input press_row_t row);
		logic ok;
		if (row.base != thr_base || row.lng != thr_long || row.hold != thr_hold)
			reconfigure(row.base, row.lng, row.hold);
		repeat (row.presses) send_key(1'b1);
		send_key(1'b0);
		in_valid <= 1'b0;
		@(negedge clk);
		case (row.rel)
			REL_NONE: begin
				ok = !last_release.valid;
			end
			REL_SHORT: begin
				ok = last_release.valid && last_release.code == EV_SHORT && !last_release.clr;
			end
			REL_LONG: begin
				ok = last_release.valid && last_release.code == EV_LONG_RELEASE &&
					last_release.clr;
			end
			default: begin
				ok = 1'b1;
			end
		endcase
		if (!ok) begin
			$error("release outcome: expected %s, predicted valid %0b code %0d",
				row.rel.name(), last_release.valid, last_release.code);
			errors++;
		end
		@(posedge clk);
	endtask

	// one press shaped around the current thresholds, sometimes after bouncing levels, then a release run
	task automatic play_press(output int sent);
		int b;
		int l;
		int h;
		int len;
		int rest;
		b    = thr_base;
		l    = thr_long;
		h    = thr_hold;
		sent = 0;
		case ($urandom_range(9))
			0, 1: begin
				len = $urandom_range(b + 2, 1);
			end
			2, 3: begin
				len = l + $urandom_range(2, 0);
			end
			4, 5, 6: begin
				len = l + 1 + h * $urandom_range(3, 1) + $urandom_range(2, 0);
			end
			7: begin
				len = 1;
			end
			8: begin
				len = $urandom_range(40, 1);
			end
			default: begin
				// bouncing levels ahead of the press
				rest = $urandom_range(8, 1);
				repeat (rest) send_key($urandom_range(1) != 0);
				sent = rest;
				len  = $urandom_range(3, 1);
			end
		endcase
		if (len < 1)
			len = 1;
		repeat (len) send_key(1'b1);
		rest = $urandom_range(3, 1);
		repeat (rest) send_key(1'b0);
		sent += len + rest;
	endtask

	initial begin : stimulus
		int sent;
		int budget;
		int waited;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i])
			play_row(directed_rows[i]);

		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin
					idle_in_pct = 0;
					stall_pct   = 0;
				end
				1: begin
					idle_in_pct = 68;
					stall_pct   = 0;
				end
				2: begin
					idle_in_pct = 0;
					stall_pct   = 68;
				end
				default: begin
					idle_in_pct = 28;
					stall_pct   = 28;
				end
			endcase
			budget = RANDOM_ITEMS / 4;
			while (budget > 0) begin
				reconfigure(pick_threshold(8), pick_threshold(14), pick_threshold(6));
				repeat (4) begin
					play_press(sent);
					budget -= sent;
				end
			end
			if (phase == 0) begin
				// counter saturation: no hold events, press just beyond the counter range
				reconfigure(8'd255, 8'd255, 8'd0);
				repeat (OVERFLOW_PRESS) send_key(1'b1);
				send_key(1'b0);
			end
		end

		in_valid <= 1'b0;
		@(posedge clk);
		waited = 0;
		while (pending_events.size() != 0 && waited < END_WAIT_CYCLES) begin
			@(posedge clk);
			waited++;
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (pending_events.size() != 0) begin
			$error("%0d expected transactions never arrived", pending_events.size());
			errors++;
		end

		$display("covered %0d key samples and %0d event transactions", samples_taken,
			events_seen);
		$display("over %0d threshold settings and four idle / stall mixes", settings_used);
		if (errors == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

	initial begin : watchdog
		#(TIMEOUT_NS);
		$display("timeout after %0d ns", TIMEOUT_NS);
		$display("status: fail");
		$finish;
	end

endmodule
